@@ src/dsf_pkg.sv @@
`default_nettype none
package dsf_pkg;

    localparam int CHAR_W = 8;
    localparam int INT_W = 64;
    localparam int FRAC_W = 32;
    localparam int CNT_W = 5;

    localparam logic [CNT_W-1:0] MAX_LENGTH = 5'd20;
    localparam logic [CNT_W-1:0] FRAC_KEPT = 5'd19;

    localparam logic [CHAR_W-1:0] CHAR_PLUS = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

    typedef logic [INT_W-1:0] t_word;

    function automatic t_word pow10(input logic [CNT_W-1:0] k);
        t_word p;
        case (k)
            5'd0: p = 64'd1;
            5'd1: p = 64'd10;
            5'd2: p = 64'd100;
            5'd3: p = 64'd1000;
            5'd4: p = 64'd10000;
            5'd5: p = 64'd100000;
            5'd6: p = 64'd1000000;
            5'd7: p = 64'd10000000;
            5'd8: p = 64'd100000000;
            5'd9: p = 64'd1000000000;
            5'd10: p = 64'd10000000000;
            5'd11: p = 64'd100000000000;
            5'd12: p = 64'd1000000000000;
            5'd13: p = 64'd10000000000000;
            5'd14: p = 64'd100000000000000;
            5'd15: p = 64'd1000000000000000;
            5'd16: p = 64'd10000000000000000;
            5'd17: p = 64'd100000000000000000;
            5'd18: p = 64'd1000000000000000000;
            5'd19: p = 64'd10000000000000000000;
            default: p = 64'd1;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

@@ src/dsf_if.sv @@
`default_nettype none
interface dsf_in_if;
    import dsf_pkg::*;
    logic valid;
    logic ready;
    logic [CHAR_W-1:0] char_code;
    logic last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface dsf_out_if;
    import dsf_pkg::*;
    logic valid;
    logic ready;
    logic valid_res;
    logic is_negative;
    logic [INT_W-1:0] integer_part;
    logic [FRAC_W-1:0] fraction_q32;
    logic overflow;

    modport source (output valid, output valid_res, output is_negative,
                     output integer_part, output fraction_q32, output overflow,
                     input ready);
    modport sink (input valid, input valid_res, input is_negative,
                   input integer_part, input fraction_q32, input overflow,
                   output ready);
endinterface
`default_nettype wire

@@ src/decimal_string_to_fixed_unit.sv @@
`default_nettype none
// Converts an ASCII decimal string, one character per item with the final character
// marked, into a sign, a saturating 64-bit integer magnitude and a truncated Q0.32
// fraction, with a flag telling whether the string was well formed. Characters before
// the final one are taken while the unit is idle. A final character that ends a
// malformed string leads straight to the done state; one that ends a well-formed string
// first runs the 32 restoring-division steps of a single shared 64-bit compare and
// subtract unit that divides the fraction digits by the matching power of ten. The result
// waits in an output register, and the next string may start while it waits.
module decimal_string_to_fixed_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dsf_in_if.sink    i_in,
    dsf_out_if.source o_out
);
    import dsf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(FRAC_W - 1);

    logic [1:0] r_state, n_state;
    logic [CNT_W-1:0] r_char_cnt, n_char_cnt;
    logic r_seen_digit, n_seen_digit;
    logic r_seen_point, n_seen_point;
    logic r_prev_point, n_prev_point;
    logic r_bad, n_bad;
    logic r_minus, n_minus;
    logic [INT_W-1:0] r_int_acc, n_int_acc;
    logic r_int_sat, n_int_sat;
    logic [INT_W-1:0] r_frac_acc, n_frac_acc;
    logic [CNT_W-1:0] r_frac_cnt, n_frac_cnt;
    logic [CNT_W-1:0] r_iter, n_iter;
    logic [FRAC_W-1:0] r_quot, n_quot;
    logic r_ok, n_ok;

    logic r_out_valid;
    logic r_res_valid;
    logic r_res_neg;
    logic [INT_W-1:0] r_res_int;
    logic [FRAC_W-1:0] r_res_frac;
    logic r_res_ovf;

    logic accept;
    logic load;
    logic is_digit;
    logic [CHAR_W-1:0] digit_w;
    logic [3:0] digit;
    logic [INT_W+3:0] int_next;
    logic [INT_W-1:0] frac_next;
    logic [INT_W-1:0] den;
    logic [INT_W-1:0] shifted;
    logic [INT_W+1:0] diff;
    logic take;
    logic ok_w;

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept = i_in.valid && i_in.ready;
    assign load = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    assign is_digit = (i_in.char_code >= CHAR_ZERO) && (i_in.char_code <= CHAR_NINE);
    assign digit_w = i_in.char_code - CHAR_ZERO;
    assign digit = digit_w[3:0];
    assign int_next = {1'b0, r_int_acc, 3'b000} + {3'b000, r_int_acc, 1'b0}
                    + {{INT_W{1'b0}}, digit};
    assign frac_next = {r_frac_acc[INT_W-4:0], 3'b000} + {r_frac_acc[INT_W-2:0], 1'b0}
                     + {{(INT_W-4){1'b0}}, digit};

    assign den = pow10(r_frac_cnt);
    assign shifted = {r_frac_acc[INT_W-2:0], 1'b0};
    assign diff = {1'b0, r_frac_acc[INT_W-1], shifted} - {2'b00, den};
    assign take = !diff[INT_W+1];

    always_comb begin
        n_state = r_state;
        n_char_cnt = r_char_cnt;
        n_seen_digit = r_seen_digit;
        n_seen_point = r_seen_point;
        n_prev_point = r_prev_point;
        n_bad = r_bad;
        n_minus = r_minus;
        n_int_acc = r_int_acc;
        n_int_sat = r_int_sat;
        n_frac_acc = r_frac_acc;
        n_frac_cnt = r_frac_cnt;
        n_iter = r_iter;
        n_quot = r_quot;
        n_ok = r_ok;
        ok_w = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (r_char_cnt >= MAX_LENGTH) begin
                        n_bad = 1'b1;
                    end else begin
                        n_char_cnt = r_char_cnt + 1'b1;
                    end
                    if ((r_char_cnt == '0) && ((i_in.char_code == CHAR_PLUS)
                            || (i_in.char_code == CHAR_MINUS))) begin
                        n_minus = (i_in.char_code == CHAR_MINUS);
                    end else if (is_digit) begin
                        n_seen_digit = 1'b1;
                        if (r_seen_point) begin
                            if (r_frac_cnt < FRAC_KEPT) begin
                                n_frac_acc = frac_next;
                                n_frac_cnt = r_frac_cnt + 1'b1;
                            end
                        end else if (r_int_sat || (int_next[INT_W+3:INT_W] != 4'd0)) begin
                            n_int_acc = '1;
                            n_int_sat = 1'b1;
                        end else begin
                            n_int_acc = int_next[INT_W-1:0];
                        end
                    end else if ((i_in.char_code == CHAR_POINT) && !r_seen_point) begin
                        n_seen_point = 1'b1;
                    end else begin
                        n_bad = 1'b1;
                    end
                    n_prev_point = (i_in.char_code == CHAR_POINT);
                    ok_w = !n_bad && n_seen_digit && !n_prev_point;
                    if (i_in.last_char) begin
                        n_ok = ok_w;
                        n_quot = '0;
                        n_iter = '0;
                        n_state = ok_w ? ST_DIV : ST_DONE;
                    end
                end
            end
            ST_DIV: begin
                n_frac_acc = take ? diff[INT_W-1:0] : shifted;
                n_quot = {r_quot[FRAC_W-2:0], take};
                n_iter = r_iter + 1'b1;
                if (r_iter == ITER_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load) begin
                    n_state = ST_IDLE;
                    n_char_cnt = '0;
                    n_seen_digit = 1'b0;
                    n_seen_point = 1'b0;
                    n_prev_point = 1'b0;
                    n_bad = 1'b0;
                    n_minus = 1'b0;
                    n_int_acc = '0;
                    n_int_sat = 1'b0;
                    n_frac_acc = '0;
                    n_frac_cnt = '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_char_cnt <= '0;
            r_seen_digit <= 1'b0;
            r_seen_point <= 1'b0;
            r_prev_point <= 1'b0;
            r_bad <= 1'b0;
            r_minus <= 1'b0;
            r_int_acc <= '0;
            r_int_sat <= 1'b0;
            r_frac_acc <= '0;
            r_frac_cnt <= '0;
            r_iter <= '0;
            r_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_char_cnt <= n_char_cnt;
            r_seen_digit <= n_seen_digit;
            r_seen_point <= n_seen_point;
            r_prev_point <= n_prev_point;
            r_bad <= n_bad;
            r_minus <= n_minus;
            r_int_acc <= n_int_acc;
            r_int_sat <= n_int_sat;
            r_frac_acc <= n_frac_acc;
            r_frac_cnt <= n_frac_cnt;
            r_iter <= n_iter;
            r_ok <= n_ok;
        end
        r_quot <= n_quot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (load) begin
            r_res_valid <= r_ok;
            r_res_neg <= r_ok && r_minus;
            r_res_int <= r_ok ? r_int_acc : '0;
            r_res_frac <= r_ok ? r_quot : '0;
            r_res_ovf <= r_ok && r_int_sat;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.valid_res = r_res_valid;
    assign o_out.is_negative = r_res_neg;
    assign o_out.integer_part = r_res_int;
    assign o_out.fraction_q32 = r_res_frac;
    assign o_out.overflow = r_res_ovf;

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !i_in.ready)
        else $error("Input taken while a conversion is in progress.");

    a_iter_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_DIV) |-> (r_iter == '0))
        else $error("Division step counter not at zero outside division.");

    a_frac_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frac_cnt <= FRAC_KEPT)
        else $error("Fraction digit count beyond the kept digits.");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.valid_res) |-> ((o_out.integer_part == '0)
            && (o_out.fraction_q32 == '0) && !o_out.is_negative && !o_out.overflow))
        else $error("Malformed string gave nonzero result fields.");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.overflow) |-> (&o_out.integer_part))
        else $error("Overflow flagged without a saturated integer part.");

    a_done_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV) && (r_iter == ITER_LAST)) |=> (r_state == ST_DONE))
        else $error("Division did not finish after its last step.");

endmodule
`default_nettype wire
